@@ hw/rtl/dfp_pkg.sv @@
// Shared widths, reset value and status codes of the dipole footprint mapper.
`default_nettype none
package dfp_pkg;

  localparam int unsigned COORD_W  = 32;  // signed Q8.24 coordinate
  localparam int unsigned RADIUS_W = 31;  // unsigned Q7.24 radius
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WIDE_W   = 64;  // squares, roots and quotients
  localparam int unsigned HORIZ_W  = 31;  // quotient bits of the horizontal divide

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 31'd17040553;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_AXIS = 2'd1,
    STATUS_LOW  = 2'd2
  } status_e;

endpackage
`default_nettype wire

@@ hw/rtl/dfp_if.sv @@
// Channel interfaces of the dipole footprint mapper: config, point in, footprint out.
`default_nettype none
interface dfp_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dfp_pkg::RADIUS_W-1:0]       footprint_radius;
  modport source (output valid, output footprint_radius, input ready);
  modport sink (input valid, input footprint_radius, output ready);
endinterface

interface dfp_pos_if;
  logic                               valid;
  logic                               ready;
  logic signed [dfp_pkg::COORD_W-1:0] pos_x;
  logic signed [dfp_pkg::COORD_W-1:0] pos_y;
  logic signed [dfp_pkg::COORD_W-1:0] pos_z;
  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

interface dfp_foot_if;
  logic                               valid;
  logic                               ready;
  logic signed [dfp_pkg::COORD_W-1:0] foot_x;
  logic signed [dfp_pkg::COORD_W-1:0] foot_y;
  logic signed [dfp_pkg::COORD_W-1:0] foot_z;
  logic [dfp_pkg::STATUS_W-1:0]       status;
  modport source (output valid, output foot_x, output foot_y, output foot_z,
                  output status, input ready);
  modport sink (input valid, input foot_x, input foot_y, input foot_z,
                input status, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/dfp_delay.sv @@
// Valid and side-data delay line that tracks an arithmetic unit's stages.
`default_nettype none
module dfp_delay #(
  parameter int unsigned DataW = 8,
  parameter int unsigned Depth = 2   // at least 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [DataW-1:0] data_i,
  output logic             valid_o,
  output logic [DataW-1:0] data_o
);

  logic [Depth-1:0] valid_q;
  logic [DataW-1:0] data_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Depth-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q[0] <= data_i;
      for (int k = 1; k < Depth; k++) begin
        data_q[k] <= data_q[k-1];
      end
    end
  end

  assign valid_o = valid_q[Depth-1];
  assign data_o  = data_q[Depth-1];

endmodule
`default_nettype wire

@@ hw/rtl/dfp_div.sv @@
// Pipelined restoring divider: one quotient bit per register stage.
`default_nettype none
module dfp_div #(
  parameter int unsigned DenW = dfp_pkg::WIDE_W,
  parameter int unsigned QuoW = dfp_pkg::WIDE_W   // at least 2
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DenW:0]     rem_i,   // numerator bits above the quotient range
  input  logic [QuoW-1:0]   low_i,   // numerator bits that yield quotient bits
  input  logic [DenW-1:0]   den_i,
  output logic [QuoW-1:0]   quo_o
);

  localparam int unsigned RemW = DenW + 1;

  logic [RemW-1:0] rem_q [QuoW];
  logic [QuoW-1:0] low_q [QuoW];
  logic [QuoW-1:0] quo_q [QuoW];
  logic [DenW-1:0] den_q [QuoW];

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [RemW-1:0] rem_in;
    logic [QuoW-1:0] low_in;
    logic [QuoW-1:0] quo_in;
    logic [DenW-1:0] den_in;
    logic [RemW:0]   shifted;
    logic [RemW:0]   diff;
    logic            take;

    if (k == 0) begin : g_first
      assign rem_in = rem_i;
      assign low_in = low_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign shifted = {rem_in, low_in[QuoW-1]};
    assign diff    = shifted - {2'b00, den_in};
    assign take    = shifted >= {2'b00, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? diff[RemW-1:0] : shifted[RemW-1:0];
        low_q[k] <= {low_in[QuoW-2:0], 1'b0};
        quo_q[k] <= {quo_in[QuoW-2:0], take};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[QuoW-1];

endmodule
`default_nettype wire

@@ hw/rtl/dfp_sqrt.sv @@
// Pipelined digit-by-digit integer square root: one root bit per register stage.
`default_nettype none
module dfp_sqrt #(
  parameter int unsigned RootW = dfp_pkg::WIDE_W   // at least 2
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [2*RootW-1:0] rad_i,
  output logic [RootW-1:0]   root_o
);

  localparam int unsigned RemW = RootW + 2;

  logic [RemW-1:0]    rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [2*RootW-1:0] rad_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RemW-1:0]    rem_in;
    logic [RootW-1:0]   root_in;
    logic [2*RootW-1:0] rad_in;
    logic [RemW+1:0]    shifted;
    logic [RemW+1:0]    trial;
    logic [RemW+1:0]    diff;
    logic               take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign shifted = {rem_in, rad_in[2*RootW-1 -: 2]};
    assign trial   = {2'b00, root_in, 2'b01};
    assign diff    = shifted - trial;
    assign take    = shifted >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? diff[RemW-1:0] : shifted[RemW-1:0];
        root_q[k] <= {root_in[RootW-2:0], take};
        rad_q[k]  <= {rad_in[2*RootW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[RootW-1];

endmodule
`default_nettype wire

@@ hw/rtl/dipole_footprint_mapper_top.sv @@
// Dipole field-line footprint mapper: maps a point to its field line's footprint on r0.
// The chain of three 64-stage units (t divide with roots, u divide, sin/cos roots) and
//   the 31-stage horizontal divide lies between an accepted point and its footprint.
//   Throughput: one point per cycle while the pipeline is not stalled.
// Stall: the pipeline holds only while the output register is full, not taken, and
//   the last stage has a result. Reset clears all valid bits; radius resets to 17040553.
`default_nettype none
module dipole_footprint_mapper_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfp_cfg_if.sink     cfg_i,
  dfp_pos_if.sink     pos_i,
  dfp_foot_if.source  foot_o
);

  localparam int unsigned CW = dfp_pkg::COORD_W;
  localparam int unsigned RW = dfp_pkg::RADIUS_W;
  localparam int unsigned WW = dfp_pkg::WIDE_W;
  localparam int unsigned HW = dfp_pkg::HORIZ_W;

  typedef struct packed {
    logic [CW+RW-1:0] ax_r0;
    logic [CW+RW-1:0] ay_r0;
    logic             neg_x;
    logic             neg_y;
    logic             neg_z;
    logic             axis;
  } tag1_t;

  typedef struct packed {
    logic [WW-1:0] rh;
    tag1_t         t1;
    logic          low;
  } tag2_t;

  typedef struct packed {
    logic [CW-1:0] zm;
    logic          sat_x;
    logic          sat_y;
    logic          neg_x;
    logic          neg_y;
    logic          neg_z;
    logic          axis;
    logic          low;
  } tag4_t;

  logic en;
  logic out_load;
  logic last_valid;

  // ---------------- configuration ----------------
  logic [RW-1:0] r0_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_q <= dfp_pkg::RADIUS_RESET;
    end else if (cfg_i.valid) begin
      r0_q <= cfg_i.footprint_radius;
    end
  end

  assign pos_i.ready = en;

  // ---------------- stage 0: capture ----------------
  logic          s0_v_q;
  logic [CW-1:0] s0_x_q, s0_y_q, s0_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q <= pos_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_x_q <= pos_i.pos_x;
      s0_y_q <= pos_i.pos_y;
      s0_z_q <= pos_i.pos_z;
    end
  end

  // ---------------- stage 1: magnitudes and squares ----------------
  logic [CW-1:0]    ax, ay, az;
  logic             s1_v_q;
  logic [WW-1:0]    s1_sqx_q, s1_sqy_q, s1_sqz_q;
  logic [CW+RW-1:0] s1_axr0_q, s1_ayr0_q;
  logic             s1_nx_q, s1_ny_q, s1_nz_q;

  assign ax = s0_x_q[CW-1] ? (~s0_x_q + 32'd1) : s0_x_q;
  assign ay = s0_y_q[CW-1] ? (~s0_y_q + 32'd1) : s0_y_q;
  assign az = s0_z_q[CW-1] ? (~s0_z_q + 32'd1) : s0_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= s0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sqx_q  <= {32'b0, ax} * {32'b0, ax};
      s1_sqy_q  <= {32'b0, ay} * {32'b0, ay};
      s1_sqz_q  <= {32'b0, az} * {32'b0, az};
      s1_axr0_q <= {31'b0, ax} * {32'b0, r0_q};
      s1_ayr0_q <= {31'b0, ay} * {32'b0, r0_q};
      s1_nx_q   <= s0_x_q[CW-1];
      s1_ny_q   <= s0_y_q[CW-1];
      s1_nz_q   <= s0_z_q[CW-1];
    end
  end

  // ---------------- stage 2: rho^2 and r^2 ----------------
  logic          s2_v_q;
  logic [WW-1:0] s2_rho2_q, s2_r2_q;
  tag1_t         s2_tag_q;
  logic [WW-1:0] rho2;

  assign rho2 = s1_sqx_q + s1_sqy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_rho2_q      <= rho2;
      s2_r2_q        <= rho2 + s1_sqz_q;
      s2_tag_q.ax_r0 <= s1_axr0_q;
      s2_tag_q.ay_r0 <= s1_ayr0_q;
      s2_tag_q.neg_x <= s1_nx_q;
      s2_tag_q.neg_y <= s1_ny_q;
      s2_tag_q.neg_z <= s1_nz_q;
      s2_tag_q.axis  <= (rho2 == '0);
    end
  end

  // ---------------- group 1: t = rho^2/r^2, rr, rh ----------------
  logic [WW-1:0] g1_t, g1_rr, g1_rh;
  logic          g1_v;
  tag1_t         g1_tag;

  dfp_div #(.DenW(WW), .QuoW(WW)) u_div_t (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i ({2'b00, s2_rho2_q[WW-1:1]}),
    .low_i ({s2_rho2_q[0], 63'b0}),
    .den_i (s2_r2_q),
    .quo_o (g1_t)
  );

  dfp_sqrt #(.RootW(WW)) u_sqrt_rr (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({s2_r2_q, 64'b0}),
    .root_o (g1_rr)
  );

  dfp_sqrt #(.RootW(WW)) u_sqrt_rh (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({s2_rho2_q, 64'b0}),
    .root_o (g1_rh)
  );

  dfp_delay #(.DataW($bits(tag1_t)), .Depth(WW)) u_dly1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s2_v_q),
    .data_i  (s2_tag_q),
    .valid_o (g1_v),
    .data_o  (g1_tag)
  );

  // ---------------- stages 3-5: n = t*r0 and shell check ----------------
  logic          s3_v_q, s4_v_q, s5_v_q;
  logic [62:0]   s3_pl_q, s3_ph_q;
  logic [94:0]   s4_p_q, s5_p_q;
  logic [WW-1:0] s3_rr_q, s4_rr_q, s5_rr_q;
  tag2_t         s3_tag_q, s4_tag_q, s5_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= g1_v;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_pl_q      <= {31'b0, g1_t[31:0]} * {32'b0, r0_q};
      s3_ph_q      <= {31'b0, g1_t[63:32]} * {32'b0, r0_q};
      s3_rr_q      <= g1_rr;
      s3_tag_q.rh  <= g1_rh;
      s3_tag_q.t1  <= g1_tag;
      s3_tag_q.low <= 1'b0;

      s4_p_q   <= {s3_ph_q, 32'b0} + {32'b0, s3_pl_q};
      s4_rr_q  <= s3_rr_q;
      s4_tag_q <= s3_tag_q;

      // shell below the sphere when t*r0*2^32 > rr*2^63
      s5_p_q       <= s4_p_q;
      s5_rr_q      <= s4_rr_q;
      s5_tag_q.rh  <= s4_tag_q.rh;
      s5_tag_q.t1  <= s4_tag_q.t1;
      s5_tag_q.low <= s4_p_q > {s4_rr_q, 31'b0};
    end
  end

  // ---------------- group 2: u = n/rr ----------------
  logic [WW-1:0] g2_u;
  logic          g2_v;
  tag2_t         g2_tag;

  dfp_div #(.DenW(WW), .QuoW(WW)) u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i ({2'b00, s5_p_q[94:32]}),
    .low_i ({s5_p_q[31:0], 32'b0}),
    .den_i (s5_rr_q),
    .quo_o (g2_u)
  );

  dfp_delay #(.DataW($bits(tag2_t)), .Depth(WW)) u_dly2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .data_i  (s5_tag_q),
    .valid_o (g2_v),
    .data_o  (g2_tag)
  );

  // ---------------- stage 6: cos^2 term ----------------
  logic          s6_v_q;
  logic [WW-1:0] s6_u_q, s6_cm_q;
  tag2_t         s6_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_v_q <= 1'b0;
    end else if (en) begin
      s6_v_q <= g2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_u_q   <= g2_u;
      s6_cm_q  <= {1'b1, 63'b0} - g2_u;
      s6_tag_q <= g2_tag;
    end
  end

  // ---------------- group 3: sin and cos roots ----------------
  logic [WW-1:0] g3_s, g3_c;
  logic          g3_v;
  tag2_t         g3_tag;

  dfp_sqrt #(.RootW(WW)) u_sqrt_s (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({1'b0, s6_u_q, 63'b0}),
    .root_o (g3_s)
  );

  dfp_sqrt #(.RootW(WW)) u_sqrt_c (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({1'b0, s6_cm_q, 63'b0}),
    .root_o (g3_c)
  );

  dfp_delay #(.DataW($bits(tag2_t)), .Depth(WW)) u_dly3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_v_q),
    .data_i  (s6_tag_q),
    .valid_o (g3_v),
    .data_o  (g3_tag)
  );

  // ---------------- stages 7-9: footprint products and saturation ----------------
  logic          s7_v_q, s8_v_q, s9_v_q;
  logic [63:0]   s7_x00_q, s7_x01_q, s7_x10_q, s7_x11_q;
  logic [63:0]   s7_y00_q, s7_y01_q, s7_y10_q, s7_y11_q;
  logic [62:0]   s7_zl_q, s7_zh_q;
  tag2_t         s7_tag_q;
  logic [126:0]  s8_nx_q, s8_ny_q, s9_nx_q, s9_ny_q;
  logic [94:0]   zw;
  logic [WW-1:0] s8_rh_q, s9_rh_q;
  tag4_t         s8_tag_q, s9_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
      s8_v_q <= 1'b0;
      s9_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= g3_v;
      s8_v_q <= s7_v_q;
      s9_v_q <= s8_v_q;
    end
  end

  assign zw = {s7_zh_q, 32'b0} + {32'b0, s7_zl_q};

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_x00_q <= {32'b0, g3_tag.t1.ax_r0[31:0]}  * {32'b0, g3_s[31:0]};
      s7_x01_q <= {32'b0, g3_tag.t1.ax_r0[31:0]}  * {32'b0, g3_s[63:32]};
      s7_x10_q <= {33'b0, g3_tag.t1.ax_r0[62:32]} * {32'b0, g3_s[31:0]};
      s7_x11_q <= {33'b0, g3_tag.t1.ax_r0[62:32]} * {32'b0, g3_s[63:32]};
      s7_y00_q <= {32'b0, g3_tag.t1.ay_r0[31:0]}  * {32'b0, g3_s[31:0]};
      s7_y01_q <= {32'b0, g3_tag.t1.ay_r0[31:0]}  * {32'b0, g3_s[63:32]};
      s7_y10_q <= {33'b0, g3_tag.t1.ay_r0[62:32]} * {32'b0, g3_s[31:0]};
      s7_y11_q <= {33'b0, g3_tag.t1.ay_r0[62:32]} * {32'b0, g3_s[63:32]};
      s7_zl_q  <= {31'b0, g3_c[31:0]}  * {32'b0, r0_q};
      s7_zh_q  <= {31'b0, g3_c[63:32]} * {32'b0, r0_q};
      s7_tag_q <= g3_tag;

      s8_nx_q <= {s7_x11_q[62:0], 64'b0} + {31'b0, s7_x01_q, 32'b0}
               + {31'b0, s7_x10_q, 32'b0} + {63'b0, s7_x00_q};
      s8_ny_q <= {s7_y11_q[62:0], 64'b0} + {31'b0, s7_y01_q, 32'b0}
               + {31'b0, s7_y10_q, 32'b0} + {63'b0, s7_y00_q};
      s8_rh_q        <= s7_tag_q.rh;
      s8_tag_q.zm    <= zw[94:63];
      s8_tag_q.sat_x <= 1'b0;
      s8_tag_q.sat_y <= 1'b0;
      s8_tag_q.neg_x <= s7_tag_q.t1.neg_x;
      s8_tag_q.neg_y <= s7_tag_q.t1.neg_y;
      s8_tag_q.neg_z <= s7_tag_q.t1.neg_z;
      s8_tag_q.axis  <= s7_tag_q.t1.axis;
      s8_tag_q.low   <= s7_tag_q.low;

      // quotient of (N >> 31) / rh reaches 2^31 exactly when N >> 62 >= rh
      s9_nx_q        <= s8_nx_q;
      s9_ny_q        <= s8_ny_q;
      s9_rh_q        <= s8_rh_q;
      s9_tag_q.zm    <= s8_tag_q.zm;
      s9_tag_q.neg_x <= s8_tag_q.neg_x;
      s9_tag_q.neg_y <= s8_tag_q.neg_y;
      s9_tag_q.neg_z <= s8_tag_q.neg_z;
      s9_tag_q.axis  <= s8_tag_q.axis;
      s9_tag_q.low   <= s8_tag_q.low;
      s9_tag_q.sat_x <= s8_nx_q[126:62] >= {1'b0, s8_rh_q};
      s9_tag_q.sat_y <= s8_ny_q[126:62] >= {1'b0, s8_rh_q};
    end
  end

  // ---------------- group 4: horizontal divides ----------------
  logic [HW-1:0] g4_qx, g4_qy;
  tag4_t         g4_tag;

  dfp_div #(.DenW(WW), .QuoW(HW)) u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (s9_nx_q[126:62]),
    .low_i (s9_nx_q[61:31]),
    .den_i (s9_rh_q),
    .quo_o (g4_qx)
  );

  dfp_div #(.DenW(WW), .QuoW(HW)) u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (s9_ny_q[126:62]),
    .low_i (s9_ny_q[61:31]),
    .den_i (s9_rh_q),
    .quo_o (g4_qy)
  );

  dfp_delay #(.DataW($bits(tag4_t)), .Depth(HW)) u_dly4 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s9_v_q),
    .data_i  (s9_tag_q),
    .valid_o (last_valid),
    .data_o  (g4_tag)
  );

  // ---------------- output register ----------------
  logic            out_v_q;
  logic [CW-1:0]   fx_q, fy_q, fz_q;
  logic [CW-1:0]   mag_x, mag_y, fx_d, fy_d, fz_d;
  dfp_pkg::status_e st_q, st_d;

  assign out_load = !out_v_q || foot_o.ready;
  // advance unless a finished result is blocked behind a full output register
  assign en       = out_load || !last_valid;

  assign mag_x = g4_tag.sat_x ? {1'b0, {HW{1'b1}}} : {1'b0, g4_qx};
  assign mag_y = g4_tag.sat_y ? {1'b0, {HW{1'b1}}} : {1'b0, g4_qy};

  always_comb begin
    st_d = dfp_pkg::STATUS_OK;
    fx_d = g4_tag.neg_x ? (~mag_x + 32'd1) : mag_x;
    fy_d = g4_tag.neg_y ? (~mag_y + 32'd1) : mag_y;
    fz_d = g4_tag.neg_z ? (~g4_tag.zm + 32'd1) : g4_tag.zm;
    if (g4_tag.axis) begin
      st_d = dfp_pkg::STATUS_AXIS;
    end else if (g4_tag.low) begin
      st_d = dfp_pkg::STATUS_LOW;
    end
    if (g4_tag.axis || g4_tag.low) begin
      fx_d = '0;
      fy_d = '0;
      fz_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= last_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
      fz_q <= fz_d;
      st_q <= st_d;
    end
  end

  assign foot_o.valid  = out_v_q;
  assign foot_o.foot_x = fx_q;
  assign foot_o.foot_y = fy_q;
  assign foot_o.foot_z = fz_q;
  assign foot_o.status = st_q;

  // ---------------- assertions ----------------
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && st_q != dfp_pkg::STATUS_OK) |->
      (fx_q == '0 && fy_q == '0 && fz_q == '0))
    else $error("flagged footprint with nonzero coordinates");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |-> (out_v_q && last_valid && !foot_o.ready))
    else $error("pipeline stalled without a blocked result");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!en && out_v_q) |=> (out_v_q && $stable(fx_q) && $stable(st_q)))
    else $error("blocked result changed during a stall");

endmodule
`default_nettype wire
